// ===== rtl/qmsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadrature missed-step monitor package
// Shared constants, types and small arithmetic helpers for the monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package qmsm_pkg;

    localparam int MOTORS          = 6;
    localparam int MOTOR_AW        = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int COUNT_W         = 32;
    localparam int THRESH_W        = 16;
    localparam int STEP_W          = 33;
    localparam int COUNTS_PER_TURN = 4000;
    localparam int THRESHOLD_RESET = 20;

    localparam logic signed [COUNT_W:0] TURN_POS = (COUNT_W + 1)'(COUNTS_PER_TURN);
    localparam logic signed [COUNT_W:0] TURN_NEG = -TURN_POS;

    // ceil(2^34 / 5): floor(x * RECIP5 / 2^34) equals floor(x / 5) for any 32-bit x.
    localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;

    typedef enum logic [1:0] {
        OP_A_EDGE = 2'd0,
        OP_B_EDGE = 2'd1,
        OP_LOAD   = 2'd2,
        OP_CHECK  = 2'd3
    } op_t;

    typedef logic [MOTOR_AW-1:0] motor_addr_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               a_level;
        logic               b_level;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // trunc(v * 5 / 8), exact: the product needs 35 bits.
    function automatic logic signed [COUNT_W-1:0] steps_to_counts(
        input logic signed [COUNT_W-1:0] v
    );
        logic signed [COUNT_W+2:0] p5;
        p5 = ((COUNT_W + 3)'(v) <<< 2) + (COUNT_W + 3)'(v);
        if (p5 < 0)
        begin
            p5 = p5 + (COUNT_W + 3)'(7);
        end
        return COUNT_W'(p5 >>> 3);
    endfunction

    // floor(8 * r / 5) for a remainder r of a division by five.
    function automatic logic [2:0] eighths_of_rem(input logic [2:0] r);
        logic [2:0] f;
        case (r)
            3'd0:    f = 3'd0;
            3'd1:    f = 3'd1;
            3'd2:    f = 3'd3;
            3'd3:    f = 3'd4;
            3'd4:    f = 3'd6;
            default: f = 3'd0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/qmsm_ifs.sv =====
// ----------------------------------------------------------------------------
// Quadrature missed-step monitor channels
// Request, result and threshold-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface qmsm_cmd_if;
    import qmsm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic [2:0]                motor;
    logic                      pin_level;
    logic signed [COUNT_W-1:0] position_value;
    logic signed [COUNT_W-1:0] goal_position;
    logic                      rewrite_enable;

    modport source (output valid, operation, motor, pin_level, position_value,
                    goal_position, rewrite_enable, input ready);
    modport sink   (input valid, operation, motor, pin_level, position_value,
                    goal_position, rewrite_enable, output ready);
endinterface

interface qmsm_res_if;
    import qmsm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COUNT_W-1:0] count_value;
    logic                      missed;
    logic                      step_rewritten;
    logic signed [STEP_W-1:0]  new_step;

    modport source (output valid, count_value, missed, step_rewritten, new_step,
                    input ready);
    modport sink   (input valid, count_value, missed, step_rewritten, new_step,
                    output ready);
endinterface

interface qmsm_cfg_if;
    import qmsm_pkg::*;
    logic                valid;
    logic                ready;
    logic [THRESH_W-1:0] missed_threshold;

    modport source (output valid, missed_threshold, input ready);
    modport sink   (input valid, missed_threshold, output ready);
endinterface

`default_nettype wire

// ===== rtl/qmsm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module qmsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                        clk,
    input  wire                                        we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                           wdata,
    input  wire                                        re,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/quadrature_missed_step_monitor_top.sv =====
// ----------------------------------------------------------------------------
// Quadrature missed-step monitor
// Per-motor quadrature counts with missed-step check and turn correction.
// ----------------------------------------------------------------------------
//  Channel | Dir | Contents
//  --------+-----+----------------------------------------------------------
//  cmd     | in  | edge, load or check request for one motor
//  res     | out | count after the request, missed flag, new step position
//  cfg     | in  | missed-step threshold write, always ready
//
//  One request per cycle is sustained while results are taken; a request's
//  result is registered through each stage in turn before it is presented
//  (RAM read with update, divide-by-five multiply, step assembly to output).
//  The per-motor state sits in a small RAM read as a request enters the update
//  stage; a bypass of the last write covers back-to-back requests to a motor.
//  Reset clears the threshold to its default and marks every motor as zero.
//  Each stage moves on when the one after it is empty or moving, so bubbles
//  close up; requests are taken while a result waits if any stage is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_missed_step_monitor_top (
    input  wire         clk,
    input  wire         rst_n,
    qmsm_cmd_if.sink    cmd,
    qmsm_res_if.source  res,
    qmsm_cfg_if.sink    cfg
);
    import qmsm_pkg::*;

    // Threshold register.
    logic [THRESH_W-1:0] thr_reg;

    // Stage enables.
    logic en1, en2, en3, en4;

    // Stage 1: request registered, RAM data arriving.
    logic                      s1_v_reg;
    op_t                       s1_op_reg;
    motor_addr_t               s1_addr_reg;
    logic                      s1_ok_reg;
    logic                      s1_lvl_reg;
    logic                      s1_rw_reg;
    logic [COUNT_W-1:0]        s1_load_reg;
    logic signed [COUNT_W-1:0] s1_step_cnt_reg;
    logic signed [COUNT_W-1:0] s1_goal_cnt_reg;

    // Last write, for forwarding into stage 1.
    logic                      lw_v_reg;
    motor_addr_t               lw_addr_reg;
    entry_t                    lw_data_reg;
    logic [MOTORS-1:0]         valid_reg;

    // Stage 2 to output.
    logic                      s2_v_reg;
    logic [COUNT_W-1:0]        s2_count_reg;
    logic                      s2_missed_reg;
    logic                      s2_rw_reg;

    logic                      s3_v_reg;
    logic [COUNT_W-1:0]        s3_count_reg;
    logic                      s3_missed_reg;
    logic                      s3_rw_reg;
    logic                      s3_neg_reg;
    logic [COUNT_W-1:0]        s3_x_reg;
    logic [29:0]               s3_q_reg;

    logic                      o_v_reg;
    logic [COUNT_W-1:0]        o_count_reg;
    logic                      o_missed_reg;
    logic                      o_rw_reg;
    logic [STEP_W-1:0]         o_step_reg;

    // Combinational signals.
    logic                      cmd_ok;
    motor_addr_t               cmd_addr;
    logic [ENTRY_W-1:0]        ram_rdata;
    entry_t                    cur;
    entry_t                    upd;
    logic                      wr_en;
    logic signed [COUNT_W:0]   err;
    logic signed [COUNT_W:0]   terr;
    logic [COUNT_W:0]          err_mag;
    logic                      flag;
    logic                      do_rw;
    logic [COUNT_W-1:0]        res_count;
    logic [COUNT_W-1:0]        abs_count;
    logic [63:0]               prod;
    logic [COUNT_W:0]          five_q;
    logic [COUNT_W-1:0]        rem_full;
    logic [STEP_W-1:0]         step_mag;
    logic [STEP_W-1:0]         step_val;

    assign en4 = !o_v_reg || res.ready;
    assign en3 = !s3_v_reg || en4;
    assign en2 = !s2_v_reg || en3;
    assign en1 = !s1_v_reg || en2;

    assign cmd.ready = en1;
    assign cfg.ready = 1'b1;

    assign cmd_ok   = (int'(cmd.motor) < MOTORS);
    assign cmd_addr = MOTOR_AW'(cmd.motor);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESH_W'(THRESHOLD_RESET);
        end
        else if (cfg.valid)
        begin
            thr_reg <= cfg.missed_threshold;
        end
    end

    qmsm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MOTORS)
    ) u_state_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (upd),
        .re    (en1),
        .raddr (cmd_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1 registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en1)
        begin
            s1_v_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_op_reg       <= op_t'(cmd.operation);
            s1_addr_reg     <= cmd_addr;
            s1_ok_reg       <= cmd_ok;
            s1_lvl_reg      <= cmd.pin_level;
            s1_rw_reg       <= cmd.rewrite_enable;
            s1_load_reg     <= cmd.position_value;
            s1_step_cnt_reg <= steps_to_counts(cmd.position_value);
            s1_goal_cnt_reg <= steps_to_counts(cmd.goal_position);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 update: resolve the entry, modify it and write it back
    // ------------------------------------------------------------------
    always_comb
    begin
        // The bypass holds the newest write, which the RAM read may have missed.
        if (lw_v_reg && (lw_addr_reg == s1_addr_reg))
        begin
            cur = lw_data_reg;
        end
        else if (valid_reg[s1_addr_reg])
        begin
            cur = entry_t'(ram_rdata);
        end
        else
        begin
            cur = '0;
        end

        upd   = cur;
        flag  = 1'b0;
        do_rw = 1'b0;
        err   = (COUNT_W + 1)'($signed(cur.count)) - (COUNT_W + 1)'(s1_step_cnt_reg);
        terr  = (COUNT_W + 1)'($signed(cur.count)) - (COUNT_W + 1)'(s1_goal_cnt_reg);
        err_mag = (err < 0) ? (COUNT_W + 1)'(-err) : (COUNT_W + 1)'(err);

        case (s1_op_reg)
            OP_A_EDGE:
            begin
                upd.count   = (s1_lvl_reg != cur.b_level) ? cur.count + 1'b1
                                                          : cur.count - 1'b1;
                upd.a_level = s1_lvl_reg;
            end
            OP_B_EDGE:
            begin
                upd.count   = (s1_lvl_reg != cur.a_level) ? cur.count - 1'b1
                                                          : cur.count + 1'b1;
                upd.b_level = s1_lvl_reg;
            end
            OP_LOAD:
            begin
                upd.count = s1_load_reg;
            end
            OP_CHECK:
            begin
                flag  = (err_mag > (COUNT_W + 1)'(thr_reg));
                do_rw = flag && s1_rw_reg;
                if (do_rw)
                begin
                    if (terr >= TURN_POS)
                    begin
                        upd.count = cur.count - COUNT_W'(COUNTS_PER_TURN);
                    end
                    else if (terr <= TURN_NEG)
                    begin
                        upd.count = cur.count + COUNT_W'(COUNTS_PER_TURN);
                    end
                end
            end
            default:
            begin
                upd = cur;
            end
        endcase

        res_count = s1_ok_reg ? upd.count : '0;
    end

    assign wr_en = s1_v_reg && en2 && s1_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_v_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            lw_v_reg               <= 1'b1;
            valid_reg[s1_addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lw_addr_reg <= s1_addr_reg;
            lw_data_reg <= upd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitude times the reciprocal of five
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en2)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_count_reg  <= res_count;
            s2_missed_reg <= flag && s1_ok_reg;
            s2_rw_reg     <= do_rw && s1_ok_reg;
        end
    end

    assign abs_count = s2_count_reg[COUNT_W-1] ? COUNT_W'(-s2_count_reg) : s2_count_reg;
    assign prod      = 64'(abs_count) * 64'(RECIP5);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en3)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_count_reg  <= s2_count_reg;
            s3_missed_reg <= s2_missed_reg;
            s3_rw_reg     <= s2_rw_reg;
            s3_neg_reg    <= s2_count_reg[COUNT_W-1];
            s3_x_reg      <= abs_count;
            s3_q_reg      <= prod[63:34];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: trunc(count * 8 / 5) = sign * (8q + floor(8r / 5))
    // ------------------------------------------------------------------
    always_comb
    begin
        five_q   = ((COUNT_W + 1)'(s3_q_reg) << 2) + (COUNT_W + 1)'(s3_q_reg);
        rem_full = s3_x_reg - COUNT_W'(five_q);
        step_mag = (STEP_W'(s3_q_reg) << 3) + STEP_W'(eighths_of_rem(rem_full[2:0]));
        if (!s3_rw_reg)
        begin
            step_val = '0;
        end
        else if (s3_neg_reg)
        begin
            step_val = STEP_W'(-step_mag);
        end
        else
        begin
            step_val = step_mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
        end
        else if (en4)
        begin
            o_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            o_count_reg  <= s3_count_reg;
            o_missed_reg <= s3_missed_reg;
            o_rw_reg     <= s3_rw_reg;
            o_step_reg   <= step_val;
        end
    end

    assign res.valid          = o_v_reg;
    assign res.count_value    = $signed(o_count_reg);
    assign res.missed         = o_missed_reg;
    assign res.step_rewritten = o_rw_reg;
    assign res.new_step       = $signed(o_step_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> s1_v_reg)
        else $error("accepted request did not reach the update stage");

    a_bypass_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (lw_v_reg && (lw_data_reg == $past(upd))
                   && valid_reg[lw_addr_reg]))
        else $error("write bypass does not hold the latest write");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && s2_v_reg && s3_v_reg && o_v_reg && !res.ready) |-> !cmd.ready)
        else $error("request taken while the pipeline is full and stalled");

    a_rewrite_needs_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_v_reg && s2_rw_reg) |-> s2_missed_reg)
        else $error("step rewrite without a missed step");

endmodule

`default_nettype wire

// ===== tb/quadrature_missed_step_monitor_top_tb.sv =====
// ----------------------------------------------------------------------------
// Quadrature missed-step monitor testbench
// Drives edge, load and check requests and threshold writes into the monitor.
// An in-bench model of the per-motor counts predicts every result, and each
// accepted result is compared with the oldest prediction. Directed cases come
// first, then random traffic under several sender and receiver idling phases.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_missed_step_monitor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qmsm_pkg::*;

    localparam longint STEPS_PER_TURN = 6400;
    localparam int     LATENCY        = 4;
    localparam int     DRAIN_CYCLES   = 2 * LATENCY;
    localparam int     STALL_LIMIT    = 1000;
    localparam int     PHASE_ITEMS    = 200;
    localparam int     REPORT_LIMIT   = 10;

    typedef struct packed {
        logic signed [COUNT_W-1:0] count;
        logic                      missed;
        logic                      rewritten;
        logic signed [STEP_W-1:0]  new_step;
    } monitor_result_t;

    logic clk;
    logic rst_n;

    qmsm_cmd_if cmd_ch ();
    qmsm_res_if res_ch ();
    qmsm_cfg_if cfg_ch ();

    quadrature_missed_step_monitor_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // Shadow of the per-motor encoder state and the threshold register.
    logic signed [COUNT_W-1:0] enc_count [MOTORS];
    logic                      a_level   [MOTORS];
    logic                      b_level   [MOTORS];
    logic [THRESH_W-1:0]       threshold;

    monitor_result_t result_q [$];
    int              mismatches     = 0;
    int              stall_cycles   = 0;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic clear_shadow();
        for (int i = 0; i < MOTORS; i++)
        begin
            enc_count[i] = '0;
            a_level[i]   = 1'b0;
            b_level[i]   = 1'b0;
        end
        threshold = THRESH_W'(THRESHOLD_RESET);
    endtask

    // Applies one request to the shadow state and returns the expected result.
    task automatic predict_request(
        input  logic [1:0]                operation,
        input  logic [2:0]                motor,
        input  logic                      lvl,
        input  logic signed [COUNT_W-1:0] pos,
        input  logic signed [COUNT_W-1:0] goal,
        input  logic                      rw,
        output monitor_result_t           r
    );
        longint cnt;
        longint err;
        longint mag;
        longint terr;
        longint steps;
        int     m;
        r = '0;
        m = int'(motor);
        if (m < MOTORS)
        begin
            case (op_t'(operation))
                OP_A_EDGE:
                begin
                    if (lvl != b_level[m])
                    begin
                        enc_count[m] = enc_count[m] + 1;
                    end
                    else
                    begin
                        enc_count[m] = enc_count[m] - 1;
                    end
                    a_level[m] = lvl;
                end
                OP_B_EDGE:
                begin
                    if (lvl != a_level[m])
                    begin
                        enc_count[m] = enc_count[m] - 1;
                    end
                    else
                    begin
                        enc_count[m] = enc_count[m] + 1;
                    end
                    b_level[m] = lvl;
                end
                OP_LOAD:
                begin
                    enc_count[m] = pos;
                end
                OP_CHECK:
                begin
                    cnt = enc_count[m];
                    err = cnt - (longint'(pos) * COUNTS_PER_TURN) / STEPS_PER_TURN;
                    mag = (err < 0) ? -err : err;
                    if (mag > longint'(threshold))
                    begin
                        r.missed = 1'b1;
                        if (rw)
                        begin
                            terr = cnt - (longint'(goal) * COUNTS_PER_TURN) / STEPS_PER_TURN;
                            if (terr >= COUNTS_PER_TURN)
                            begin
                                enc_count[m] = enc_count[m] - COUNTS_PER_TURN;
                            end
                            else if (terr <= -COUNTS_PER_TURN)
                            begin
                                enc_count[m] = enc_count[m] + COUNTS_PER_TURN;
                            end
                            cnt         = enc_count[m];
                            steps       = (cnt * STEPS_PER_TURN) / COUNTS_PER_TURN;
                            r.new_step  = steps[STEP_W-1:0];
                            r.rewritten = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            r.count = enc_count[m];
        end
    endtask

    // Result check first, then prediction of the request taken at this edge,
    // so that ordering within the edge never matters.
    always @(posedge clk)
    begin : monitor
        monitor_result_t got;
        monitor_result_t want;
        if (res_ch.valid && res_ch.ready)
        begin
            got.count     = res_ch.count_value;
            got.missed    = res_ch.missed;
            got.rewritten = res_ch.step_rewritten;
            got.new_step  = res_ch.new_step;
            if (result_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("unexpected result: count %0d missed %0b rewritten %0b new_step %0d",
                             got.count, got.missed, got.rewritten, got.new_step);
                end
            end
            else
            begin
                want = result_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("mismatch: expected count %0d missed %0b rewritten %0b new_step %0d",
                                 want.count, want.missed, want.rewritten, want.new_step);
                        $display("          actual   count %0d missed %0b rewritten %0b new_step %0d",
                                 got.count, got.missed, got.rewritten, got.new_step);
                    end
                end
            end
        end
        if (cmd_ch.valid && cmd_ch.ready)
        begin
            predict_request(cmd_ch.operation, cmd_ch.motor, cmd_ch.pin_level,
                            cmd_ch.position_value, cmd_ch.goal_position,
                            cmd_ch.rewrite_enable, want);
            result_q.push_back(want);
        end
        if (cfg_ch.valid && cfg_ch.ready)
        begin
            threshold = cfg_ch.missed_threshold;
        end
    end

    always @(negedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("quadrature_missed_step_monitor_top regression: fail");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so a following request keeps it up.
    task automatic send_request(
        input op_t                       op,
        input logic [2:0]                motor,
        input logic                      lvl,
        input logic signed [COUNT_W-1:0] pos,
        input logic signed [COUNT_W-1:0] goal,
        input logic                      rw
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.operation      <= op;
        cmd_ch.motor          <= motor;
        cmd_ch.pin_level      <= lvl;
        cmd_ch.position_value <= pos;
        cmd_ch.goal_position  <= goal;
        cmd_ch.rewrite_enable <= rw;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (result_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Only issued once the block is idle.
    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.missed_threshold <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_edge_counting();
        send_request(OP_A_EDGE, 0, 1'b1, 0, 0, 1'b0);
        send_request(OP_B_EDGE, 0, 1'b1, -1, -1, 1'b1);
        send_request(OP_A_EDGE, 0, 1'b0, 0, 0, 1'b0);
        send_request(OP_B_EDGE, 0, 1'b0, 0, 0, 1'b0);
        send_request(OP_B_EDGE, 0, 1'b1, 0, 0, 1'b0);
    endtask

    task automatic test_count_wrap();
        send_request(OP_LOAD, 2, 1'b0, 32'sh7FFF_FFFF, 0, 1'b0);
        send_request(OP_A_EDGE, 2, 1'b1, 0, 0, 1'b0);
        send_request(OP_LOAD, 2, 1'b0, 32'sh8000_0000, 0, 1'b0);
        send_request(OP_A_EDGE, 2, 1'b0, 0, 0, 1'b0);
    endtask

    // Motor indices past the last motor must leave every count alone.
    task automatic test_motor_out_of_range();
        send_request(OP_LOAD, 6, 1'b1, 123, 0, 1'b0);
        send_request(OP_CHECK, 7, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
        send_request(OP_A_EDGE, 7, 1'b1, 0, 0, 1'b0);
    endtask

    task automatic test_check_and_rewrite();
        send_request(OP_LOAD, 3, 1'b0, 5000, 0, 1'b0);
        send_request(OP_CHECK, 3, 1'b0, 0, 0, 1'b0);
        send_request(OP_CHECK, 3, 1'b0, 0, 0, 1'b1);
        send_request(OP_LOAD, 3, 1'b0, -5000, 0, 1'b0);
        send_request(OP_CHECK, 3, 1'b0, 0, 0, 1'b1);
        send_request(OP_CHECK, 3, 1'b0, 8000, -1600, 1'b1);
        send_request(OP_CHECK, 4, 1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
        send_request(OP_CHECK, 4, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    endtask

    task automatic test_threshold_bounds();
        drain_results();
        write_threshold('0);
        send_request(OP_CHECK, 1, 1'b0, 0, 0, 1'b1);
        // A step position of -2 rounds towards zero to -1 count, not to -2.
        send_request(OP_CHECK, 1, 1'b0, -2, 0, 1'b1);
        drain_results();
        write_threshold('1);
        send_request(OP_LOAD, 1, 1'b0, 65535, 0, 1'b0);
        send_request(OP_CHECK, 1, 1'b0, 0, 0, 1'b0);
        send_request(OP_A_EDGE, 1, 1'b1, 0, 0, 1'b0);
        send_request(OP_CHECK, 1, 1'b0, 0, 0, 1'b1);
        drain_results();
        write_threshold(THRESH_W'(THRESHOLD_RESET));
    endtask

    task automatic send_random_request();
        int     kind;
        int     m;
        int     span;
        int     d;
        int     k;
        logic signed [COUNT_W-1:0] value;
        longint target;
        longint pos_l;
        longint goal_l;
        kind = $urandom_range(99);
        if (kind < 45)
        begin
            // Proper quadrature: the line that moves toggles its level.
            m = $urandom_range(MOTORS - 1);
            if ($urandom_range(1))
            begin
                send_request(OP_A_EDGE, 3'(m), !a_level[m], $urandom, $urandom,
                             1'($urandom_range(1)));
            end
            else
            begin
                send_request(OP_B_EDGE, 3'(m), !b_level[m], $urandom, $urandom,
                             1'($urandom_range(1)));
            end
        end
        else if (kind < 55)
        begin
            send_request(op_t'($urandom_range(1)), 3'($urandom_range(7)),
                         1'($urandom_range(1)), $urandom, $urandom,
                         1'($urandom_range(1)));
        end
        else if (kind < 65)
        begin
            case ($urandom_range(3))
                0:       value = $urandom;
                1:       value = 32'sh7FFF_FFF8 + int'($urandom_range(15));
                2:       value = int'($urandom_range(200000)) - 100000;
                default: value = (int'($urandom_range(6)) - 3) * COUNTS_PER_TURN
                                 + int'($urandom_range(64)) - 32;
            endcase
            send_request(OP_LOAD, 3'($urandom_range(MOTORS - 1)), 1'($urandom_range(1)),
                         value, $urandom, 1'($urandom_range(1)));
        end
        else if (kind < 93)
        begin
            // Step position chosen so the error lands near the threshold, and
            // a goal near whole turns away so the correction edge is hit.
            m    = $urandom_range(MOTORS - 1);
            span = int'(threshold) + 8;
            d    = int'($urandom_range(2 * span)) - span;
            if ($urandom_range(3) == 0)
            begin
                d = int'($urandom_range(20000)) - 10000;
            end
            target = longint'(enc_count[m]) - d;
            pos_l  = (target * STEPS_PER_TURN) / COUNTS_PER_TURN + int'($urandom_range(1));
            k      = int'($urandom_range(4)) - 2;
            goal_l = pos_l + k * STEPS_PER_TURN + (int'($urandom_range(32)) - 16);
            send_request(OP_CHECK, 3'(m), 1'($urandom_range(1)), pos_l[COUNT_W-1:0],
                         goal_l[COUNT_W-1:0], $urandom_range(9) != 0);
        end
        else
        begin
            send_request(op_t'($urandom_range(3)), 3'($urandom_range(7)),
                         1'($urandom_range(1)), $urandom, $urandom,
                         1'($urandom_range(1)));
        end
    endtask

    task automatic run_random_phase(
        input int                  send_pct,
        input int                  recv_pct,
        input logic [THRESH_W-1:0] thr
    );
        drain_results();
        write_threshold(thr);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (PHASE_ITEMS) send_random_request();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, '0);
        run_random_phase(47, 0, '1);
        run_random_phase(0, 47, THRESH_W'($urandom_range(300)));
        run_random_phase(38, 38, THRESH_W'(THRESHOLD_RESET));
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        cmd_ch.valid            = 1'b0;
        cmd_ch.operation        = OP_A_EDGE;
        cmd_ch.motor            = '0;
        cmd_ch.pin_level        = 1'b0;
        cmd_ch.position_value   = '0;
        cmd_ch.goal_position    = '0;
        cmd_ch.rewrite_enable   = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.missed_threshold = '0;
        res_ch.ready            = 1'b0;
        clear_shadow();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_threshold(THRESH_W'(THRESHOLD_RESET));

        test_edge_counting();
        test_count_wrap();
        test_motor_out_of_range();
        test_check_and_rewrite();
        test_threshold_bounds();
        test_random_traffic();

        drain_results();
        if (mismatches == 0 && result_q.size() == 0)
        begin
            $display("quadrature_missed_step_monitor_top regression: pass");
        end
        else
        begin
            $display("quadrature_missed_step_monitor_top regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
